// File: design/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define MSP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

	// field widths
	localparam int CMD_W        = 2;
	localparam int VALUE_W      = 16;
	localparam int TICK_CLOCK_W = 24;
	localparam int GAIN_W       = 10;
	localparam int DUTY_W       = 8;
	localparam int TARGET_W     = 6;
	localparam int SDIV_W       = 8;
	localparam int SPEED_W      = 16;
	localparam int ERR_W        = 8;
	localparam int POT_W        = 8;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_TICK_CLOCK     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SUM       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_DUTY   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DESIRED_LIMIT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DIVIDER = 3'd5;

	// register reset values
	localparam logic [TICK_CLOCK_W-1:0] TICK_CLOCK_RST     = 24'd250000;
	localparam logic [GAIN_W-1:0]       GAIN_P_RST         = 10'd102;
	localparam logic [GAIN_W-1:0]       GAIN_SUM_RST       = 10'd179;
	localparam logic [DUTY_W-1:0]       INITIAL_DUTY_RST   = 8'd30;
	localparam logic [TARGET_W-1:0]     DESIRED_LIMIT_RST  = 6'd50;
	localparam logic [SDIV_W-1:0]       SAMPLE_DIVIDER_RST = 8'd10;

	// commands
	localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd2;

	// saturation bounds
	localparam logic [ERR_W-1:0]    ERR_MAX   = 8'h7f;
	localparam logic [ERR_W-1:0]    ERR_MIN   = 8'h80;
	localparam logic [DUTY_W-1:0]   DUTY_MAX  = 8'hff;
	localparam logic [SPEED_W-1:0]  SPEED_MAX = 16'hffff;

	// parameter defaults
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int PERIOD_WIDTH_DEF   = 16;

	// result packing
	localparam int OUT_FIELDS_W = DUTY_W + SPEED_W + TARGET_W + ERR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_sum;
	} gains_t;

	typedef struct packed {
		logic              done;
		logic [DUTY_W-1:0] duty;
		logic [ERR_W-1:0]  err;
	} pi_res_t;

endpackage

// File: design/msp_div.sv
`timescale 1ns / 1ps

module msp_div import msp_pkg::*; #(
	parameter int DIVISOR_W = PERIOD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [TICK_CLOCK_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]    divisor,
	output logic                    done,
	output logic [TICK_CLOCK_W-1:0] quotient
);

	localparam int CNT_W = $clog2(TICK_CLOCK_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_CLOCK_W - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIVISOR_W-1:0]    rem_q;
	logic [DIVISOR_W-1:0]    dsr_q;
	logic [TICK_CLOCK_W-1:0] quo_q;

	logic [DIVISOR_W:0] cand;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	// restoring step: one quotient bit per cycle, dividend shifted out msb first
	assign cand = {rem_q, quo_q[TICK_CLOCK_W-1]};
	assign diff = cand - {1'b0, dsr_q};
	assign fits = cand >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : cand[DIVISOR_W-1:0];
			quo_q <= {quo_q[TICK_CLOCK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/msp_pi.sv
`timescale 1ns / 1ps

module msp_pi import msp_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [TARGET_W-1:0] target,
	input  logic [SPEED_W-1:0]  speed,
	input  logic [DUTY_W-1:0]   duty,
	input  gains_t              gains,
	output pi_res_t             res
);

	localparam int PROD_W = GAIN_W + 1 + ERR_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((1 << GAIN_FRAC_BITS) - 1);

	localparam logic [1:0] PS_IDLE = 2'd0;
	localparam logic [1:0] PS_MSUM = 2'd1;
	localparam logic [1:0] PS_MP   = 2'd2;
	localparam logic [1:0] PS_FIN  = 2'd3;

	logic [1:0]              step_q;
	logic signed [ERR_W-1:0] e_q;
	logic signed [ERR_W-1:0] e_prev_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [SPEED_W:0]  diff;
	logic [ERR_W-1:0]         e_sat;
	logic signed [GAIN_W:0]   mul_a;
	logic signed [ERR_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_b;
	logic signed [ACC_W-1:0]  quo;
	logic signed [ACC_W-1:0]  duty_sum;
	logic [DUTY_W-1:0]        duty_sat;

	// error, saturated to the signed byte range
	assign diff = $signed({{(SPEED_W - TARGET_W + 1){1'b0}}, target})
		- $signed({1'b0, speed});

	always_comb begin
		if (!diff[SPEED_W] && (|diff[SPEED_W-1:ERR_W-1])) begin
			e_sat = ERR_MAX;
		end else if (diff[SPEED_W] && !(&diff[SPEED_W-1:ERR_W-1])) begin
			e_sat = ERR_MIN;
		end else begin
			e_sat = diff[ERR_W-1:0];
		end
	end

	// one multiplier, used for the sum gain and then for the proportional gain
	assign mul_a    = $signed({1'b0, (step_q == PS_MSUM) ? gains.gain_sum : gains.gain_p});
	assign mul_b    = (step_q == PS_MSUM) ? e_q : e_prev_q;
	assign prod     = mul_a * mul_b;
	assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

	// scale down with truncation toward zero, then add to the duty and clamp
	assign acc_b    = acc_q[ACC_W-1] ? acc_q + BIAS : acc_q;
	assign quo      = acc_b >>> GAIN_FRAC_BITS;
	assign duty_sum = $signed({{(ACC_W - DUTY_W){1'b0}}, duty}) + quo;

	always_comb begin
		if (duty_sum[ACC_W-1]) begin
			duty_sat = '0;
		end else if (|duty_sum[ACC_W-2:DUTY_W]) begin
			duty_sat = DUTY_MAX;
		end else begin
			duty_sat = duty_sum[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= PS_IDLE;
			e_q      <= '0;
			e_prev_q <= '0;
		end else begin
			unique case (step_q)
				PS_IDLE: begin
					if (start) begin
						e_prev_q <= e_q;
						e_q      <= e_sat;
						step_q   <= PS_MSUM;
					end
				end
				PS_MSUM: step_q <= PS_MP;
				PS_MP:   step_q <= PS_FIN;
				PS_FIN:  step_q <= PS_IDLE;
				default: step_q <= PS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == PS_MSUM) begin
			acc_q <= prod_ext;
		end else if (step_q == PS_MP) begin
			acc_q <= acc_q - prod_ext;
		end
	end

	assign res.done = (step_q == PS_FIN);
	assign res.duty = duty_sat;
	assign res.err  = e_q;

endmodule

// File: design/motor_speed_pi_controller_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Motor speed loop with an incremental PI controller.
// Input channel s_*: one event per transfer, s_tuser is the command (capture,
// tick, set target), s_tdata the period or the pot byte. Every event gives
// exactly one result on m_*: duty, speed, target and error in m_tdata, and
// m_tuser high when the event ran a controller step.
// Configuration: cfg_we writes cfg_wdata into the register picked by
// cfg_index; an initial_duty write also loads the duty at once.
// A capture with a nonzero period runs the serial divider, one quotient bit
// per cycle; a tick that runs a step makes two passes through the one shared
// multiplier; every other event goes straight to the done state. One event
// is in work at a time; s_tready is high only while the block is idle, so the
// next transfer waits until the event in work has passed on its result.
// Results sit in an output register; the next event is taken while that
// result waits. When the receiver stalls, a finished event waits until the
// register frees and input is held off meanwhile.
// Reset clears target, speed, errors and tick count, loads the duty and all
// registers with their defaults; there is no clearing pass.

module motor_speed_pi_controller_top import msp_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int PERIOD_WIDTH   = PERIOD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VALUE_W-1:0]     s_tdata,   // value
	input  logic [CMD_W-1:0]       s_tuser,   // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // duty, speed, target, error, zero pad
	output logic                   m_tuser,   // updated
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PER_W = (PERIOD_WIDTH < VALUE_W) ? PERIOD_WIDTH : VALUE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PI   = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [TICK_CLOCK_W-1:0] tick_clock_q;
	gains_t                  gains_q;
	logic [TARGET_W-1:0]     limit_q;
	logic [SDIV_W-1:0]       sdiv_q;

	logic [TARGET_W-1:0] target_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [SDIV_W-1:0]   tick_q;
	logic                ran_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic                    in_xfer;
	logic [PER_W-1:0]        period;
	logic [SDIV_W-1:0]       tick_next;
	logic [TARGET_W-1:0]     pot;
	logic                    div_start;
	logic                    div_done;
	logic [TICK_CLOCK_W-1:0] div_quo;
	logic                    pi_start;
	pi_res_t                 pi_res;
	logic                    out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign period    = s_tdata[PER_W-1:0];
	assign tick_next = tick_q + 1'b1;
	assign pot       = s_tdata[POT_W-1:POT_W-TARGET_W];
	assign div_start = in_xfer && (s_tuser == CMD_CAPTURE) && (period != '0);
	assign pi_start  = in_xfer && (s_tuser == CMD_TICK) && (tick_next == sdiv_q);
	assign out_free  = !m_tvalid_q || m_tready;

	msp_div #(
		.DIVISOR_W (PER_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tick_clock_q),
		.divisor  (period),
		.done     (div_done),
		.quotient (div_quo)
	);

	msp_pi #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_pi (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pi_start),
		.target (target_q),
		.speed  (speed_q),
		.duty   (duty_q),
		.gains  (gains_q),
		.res    (pi_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_clock_q     <= TICK_CLOCK_RST;
			gains_q.gain_p   <= GAIN_P_RST;
			gains_q.gain_sum <= GAIN_SUM_RST;
			limit_q          <= DESIRED_LIMIT_RST;
			sdiv_q           <= SAMPLE_DIVIDER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_CLOCK:     tick_clock_q     <= cfg_wdata[TICK_CLOCK_W-1:0];
				REG_GAIN_P:         gains_q.gain_p   <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_SUM:       gains_q.gain_sum <= cfg_wdata[GAIN_W-1:0];
				// initial_duty only presets the duty, done in the sequencer
				REG_INITIAL_DUTY:   ;
				REG_DESIRED_LIMIT:  limit_q          <= cfg_wdata[TARGET_W-1:0];
				REG_SAMPLE_DIVIDER: sdiv_q           <= cfg_wdata[SDIV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			target_q <= '0;
			speed_q  <= '0;
			duty_q   <= INITIAL_DUTY_RST;
			tick_q   <= '0;
			ran_q    <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_INITIAL_DUTY)) begin
				duty_q <= cfg_wdata[DUTY_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ran_q   <= 1'b0;
						state_q <= ST_DONE;
						unique case (s_tuser)
							CMD_CAPTURE: begin
								if (period == '0) begin
									speed_q <= '0;
								end else begin
									state_q <= ST_DIV;
								end
							end
							CMD_TICK: begin
								if (tick_next == sdiv_q) begin
									tick_q  <= '0;
									ran_q   <= 1'b1;
									state_q <= ST_PI;
								end else begin
									tick_q <= tick_next;
								end
							end
							CMD_SET: begin
								target_q <= (pot > limit_q) ? limit_q : pot;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q <= (|div_quo[TICK_CLOCK_W-1:SPEED_W]) ? SPEED_MAX
							: div_quo[SPEED_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_PI: begin
					if (pi_res.done) begin
						duty_q  <= pi_res.duty;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, pi_res.err, target_q,
				speed_q, duty_q};
			m_tuser_q <= ran_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`MSP_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV), "divider done outside divide state")
	`MSP_ASSERT(a_pi_done_in_pi, pi_res.done |-> (state_q == ST_PI), "pi step done outside pi state")
	`MSP_ASSERT(a_pi_start_enters_pi, pi_start |=> (state_q == ST_PI), "pi start did not enter pi state")
	`MSP_NEVER(a_duty_change_cause, !$stable(duty_q) && !$past(pi_res.done) && !$past(cfg_we && (cfg_index == REG_INITIAL_DUTY)), "duty changed without a step or preset")

endmodule
